// ===== hw/rtl/sha1md_pkg.sv =====
// sha1md_pkg: payload types and fixed constants for the sha-1 digest block
// no dependencies; imported by sha1_message_digest and sha1md_checker
`default_nettype none

package sha1md_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  localparam int unsigned NumHashWords = 5;

  // initial hash values, entry 0 is H0
  localparam logic [NumHashWords-1:0][31:0] ShaIv = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] ShaK0 = 32'h5A827999;
  localparam logic [31:0] ShaK1 = 32'h6ED9EBA1;
  localparam logic [31:0] ShaK2 = 32'h8F1BBCDC;
  localparam logic [31:0] ShaK3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark     = 8'h80;
  localparam logic [5:0] LenBytePos  = 6'd56;
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [6:0] LastRound   = 7'd79;
  localparam logic [2:0] LastWordIdx = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/sha1_message_digest.sv =====
// sha1_message_digest: byte-stream sha-1 hash with built-in padding, one round per cycle
// depends on sha1md_pkg (payload structs, initial values, round constants)
//
// Message bytes are taken one per cycle while the block is idle and packed big-endian
// into a 16-word schedule window. The 64th byte of a block starts a compression that
// holds in_stall_o high through the load, 80 rounds through the single round adder and
// the hash update. A transaction with last_byte set (with or without a byte) starts
// padding: the 0x80 mark, zero fill and the 8 length bytes go through the same byte
// path at one byte per cycle, with one or two more compressions. Then the five hash
// words H0..H4 leave on the output channel, one per transaction, and the block is
// ready for the next message while the final word still waits in the output register.
`default_nettype none

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output       logic in_stall_o,
  input  wire  in_t  in_data_i,
  output       logic out_valid_o,
  input  wire  logic out_stall_i,
  output       out_t out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StHadd  = 3'd3;
  localparam logic [2:0] StPmark = 3'd4;
  localparam logic [2:0] StPzero = 3'd5;
  localparam logic [2:0] StPlen  = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [2:0]  ret_q, ret_d;
  logic [5:0]  pos_q, pos_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_valid_q, out_valid_d;
  logic [NumHashWords-1:0][31:0] hash_q, hash_d;

  logic [23:0] acc_q;
  logic [15:0][31:0] win_q;
  logic [NumHashWords-1:0][31:0] work_q;
  out_t        out_q;

  logic        in_acc;
  logic        byte_vld;
  logic [7:0]  byte_val;
  logic [7:0]  len_sh;
  logic        out_load;
  logic [31:0] sel_word;

  logic [31:0] ra, rb, rc, rd, re, rf, rk, rt, wsched;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // length bytes, most significant first, at block positions 56..63
  assign len_sh = 8'(bitlen_q >> {~pos_q[2:0], 3'b000});

  always_comb begin
    byte_vld = 1'b0;
    byte_val = 8'h00;
    case (state_q)
      StIdle: begin
        byte_vld = in_acc && in_data_i.has_byte;
        byte_val = in_data_i.msg_byte;
      end
      StPmark: begin
        byte_vld = 1'b1;
        byte_val = PadMark;
      end
      StPzero: begin
        byte_vld = (pos_q != LenBytePos);
      end
      StPlen: begin
        byte_vld = 1'b1;
        byte_val = len_sh;
      end
      default: begin
        byte_vld = 1'b0;
      end
    endcase
  end

  // round function
  assign ra = work_q[0];
  assign rb = work_q[1];
  assign rc = work_q[2];
  assign rd = work_q[3];
  assign re = work_q[4];

  always_comb begin
    if (rnd_q < 7'd20) begin
      rf = (rb & rc) | (~rb & rd);
      rk = ShaK0;
    end else if (rnd_q < 7'd40) begin
      rf = rb ^ rc ^ rd;
      rk = ShaK1;
    end else if (rnd_q < 7'd60) begin
      rf = (rb & rc) | (rb & rd) | (rc & rd);
      rk = ShaK2;
    end else begin
      rf = rb ^ rc ^ rd;
      rk = ShaK3;
    end
  end

  assign rt     = {ra[26:0], ra[31:27]} + rf + re + rk + win_q[0];
  assign wsched = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];

  always_comb begin
    case (out_idx_q)
      3'd0:    sel_word = hash_q[0];
      3'd1:    sel_word = hash_q[1];
      3'd2:    sel_word = hash_q[2];
      3'd3:    sel_word = hash_q[3];
      default: sel_word = hash_q[4];
    endcase
  end

  assign out_load = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pos_d       = pos_q;
    rnd_d       = rnd_q;
    bitlen_d    = bitlen_q;
    out_idx_d   = out_idx_q;
    out_valid_d = out_valid_q;
    hash_d      = hash_q;

    if (byte_vld) begin
      pos_d = pos_q + 6'd1;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.has_byte) begin
            bitlen_d = bitlen_q + 64'd8;
          end
          if (in_data_i.has_byte && pos_q == LastBytePos) begin
            state_d = StLoad;
            ret_d   = in_data_i.last_byte ? StPmark : StIdle;
          end else if (in_data_i.last_byte) begin
            state_d = StPmark;
          end
        end
      end
      StLoad: begin
        rnd_d   = '0;
        state_d = StRound;
      end
      StRound: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LastRound) begin
          rnd_d   = '0;
          state_d = StHadd;
        end
      end
      StHadd: begin
        for (int i = 0; i < NumHashWords; i++) begin
          hash_d[i] = hash_q[i] + work_q[i];
        end
        out_idx_d = '0;
        state_d   = ret_q;
      end
      StPmark: begin
        if (pos_q == LastBytePos) begin
          state_d = StLoad;
          ret_d   = StPzero;
        end else begin
          state_d = StPzero;
        end
      end
      StPzero: begin
        if (pos_q == LenBytePos) begin
          state_d = StPlen;
        end else if (pos_q == LastBytePos) begin
          state_d = StLoad;
          ret_d   = StPzero;
        end
      end
      StPlen: begin
        if (pos_q == LastBytePos) begin
          state_d = StLoad;
          ret_d   = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_idx_d   = out_idx_q + 3'd1;
          if (out_idx_q == LastWordIdx) begin
            hash_d   = ShaIv;
            bitlen_d = '0;
            pos_d    = '0;
            state_d  = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      pos_q       <= '0;
      rnd_q       <= '0;
      bitlen_q    <= '0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
      hash_q      <= ShaIv;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pos_q       <= pos_d;
      rnd_q       <= rnd_d;
      bitlen_q    <= bitlen_d;
      out_idx_q   <= out_idx_d;
      out_valid_q <= out_valid_d;
      hash_q      <= hash_d;
    end
  end

  // datapath: byte packing, schedule window, working registers, output register
  always_ff @(posedge clk_i) begin
    if (byte_vld) begin
      acc_q <= {acc_q[15:0], byte_val};
      if (pos_q[1:0] == 2'b11) begin
        win_q <= {{acc_q, byte_val}, win_q[15:1]};
      end
    end
    if (state_q == StLoad) begin
      work_q <= hash_q;
    end
    if (state_q == StRound) begin
      // window always holds w[t..t+15]; the new word is w[t+16]
      win_q  <= {{wsched[30:0], wsched[31]}, win_q[15:1]};
      work_q <= {rd, rc, {rb[1:0], rb[31:2]}, ra, rt};
    end
    if (out_load) begin
      out_q.digest_word <= sel_word;
      out_q.word_index  <= out_idx_q;
      out_q.last_word   <= (out_idx_q == LastWordIdx);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sha1md_checker.sv =====
// sha1md_checker: port-level checks on the digest output sequence, bound to the top level
// depends on sha1md_pkg (out_t, LastWordIdx) and sha1_message_digest
`default_nettype none

module sha1md_checker
  import sha1md_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  // last flag marks exactly the fifth word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == LastWordIdx)))
    else $error("last_word does not match word_index");

  // words follow each other without gaps and in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_data_o.last_word |=>
      out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("digest word sequence broken");

  // no new input while the digest is still going out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_word |-> in_stall_o)
    else $error("input taken during digest output");

  // stalled transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
